// ----- hdl/msap_pkg.sv -----
// shared types, control word layout and microcode program of the mid/side residual block
package msap_pkg;

  // wait condition a step holds on before it acts
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  // datapath operation of a step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_WALK,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_FINISH
  } op_t;

  // jump condition, tested when the step acts
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_IDX_MORE,
    JMP_USED_ZERO,
    JMP_DIV_MORE
  } jmp_t;

  typedef logic [2:0] upc_t;

  // program addresses
  localparam upc_t UPC_LOAD     = 3'd0;
  localparam upc_t UPC_WALK     = 3'd1;
  localparam upc_t UPC_DIV_LOAD = 3'd2;
  localparam upc_t UPC_DIV_STEP = 3'd3;
  localparam upc_t UPC_FINISH   = 3'd4;

  // one control word
  typedef struct packed {
    wait_t wt;
    op_t   op;
    jmp_t  jc;
    upc_t  target;
  } ucw_t;

  // status from the datapath for jump tests
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic idx_more;
    logic used_zero;
    logic div_more;
  } seq_status_t;

  // sequencer outputs
  typedef struct packed {
    op_t  op;
    logic fire;
    logic in_ready;
  } seq_ctrl_t;

  // strobes to each channel lane
  typedef struct packed {
    logic load;
    logic walk;
    logic div_load;
    logic div_step;
    logic finish;
  } lane_ctrl_t;

  // microcode program
  function automatic ucw_t ucode_rom(input upc_t pc);
    ucw_t w;
    unique case (pc)
      UPC_LOAD:     w = '{wt: WAIT_IN,   op: OP_LOAD,     jc: JMP_NEVER,     target: UPC_LOAD};
      UPC_WALK:     w = '{wt: WAIT_NONE, op: OP_WALK,     jc: JMP_IDX_MORE,  target: UPC_WALK};
      UPC_DIV_LOAD: w = '{wt: WAIT_NONE, op: OP_DIV_LOAD, jc: JMP_USED_ZERO, target: UPC_FINISH};
      UPC_DIV_STEP: w = '{wt: WAIT_NONE, op: OP_DIV_STEP, jc: JMP_DIV_MORE,  target: UPC_DIV_STEP};
      UPC_FINISH:   w = '{wt: WAIT_OUT,  op: OP_FINISH,   jc: JMP_ALWAYS,    target: UPC_LOAD};
      default:      w = '{wt: WAIT_NONE, op: OP_NOP,      jc: JMP_ALWAYS,    target: UPC_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/msap_seq.sv -----
// microcode sequencer: step counter, program rom and jump logic
module msap_seq import msap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output seq_ctrl_t   ctrl
);

  upc_t pc;
  upc_t pc_next;
  ucw_t cw;
  logic fire;
  logic take;

  assign cw = ucode_rom(pc);

  // wait condition
  always_comb begin
    case (cw.wt)
      WAIT_IN:  fire = status.in_valid;
      WAIT_OUT: fire = status.out_free;
      default:  fire = 1'b1;
    endcase
  end

  // jump condition
  always_comb begin
    case (cw.jc)
      JMP_ALWAYS:    take = 1'b1;
      JMP_IDX_MORE:  take = status.idx_more;
      JMP_USED_ZERO: take = status.used_zero;
      JMP_DIV_MORE:  take = status.div_more;
      default:       take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (!fire) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UPC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // control out
  assign ctrl.op       = fire ? cw.op : OP_NOP;
  assign ctrl.fire     = fire;
  assign ctrl.in_ready = (cw.wt == WAIT_IN);

endmodule

// ----- hdl/msap_lane.sv -----
// one channel lane: history line, running-sum walk, serial divider, residual
module msap_lane import msap_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_ORDER   = 16
) (
  input  logic                              clk,
  input  lane_ctrl_t                        ctrl,
  input  logic signed [SAMPLE_BITS:0]       v2_in,
  input  logic [$clog2(MAX_ORDER)-1:0]      idx,
  input  logic [$clog2(MAX_ORDER)-1:0]      used,
  output logic signed [SAMPLE_BITS:0]       residual
);

  localparam int V2W  = SAMPLE_BITS + 1;
  localparam int IW   = $clog2(MAX_ORDER);
  localparam int HD   = MAX_ORDER - 1;
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int ACCW = SAMPLE_BITS + IW + 1;
  localparam int MAGW = ACCW - 1;
  localparam int DVW  = IW;
  localparam int DW   = ACCW + 2;

  logic signed [V2W-1:0]  hist [HD];
  logic signed [V2W-1:0]  v2;
  logic signed [ACCW-1:0] acc;
  logic                   neg;
  logic [DVW-1:0]         rem;
  logic [MAGW-1:0]        quo;

  logic [IW-1:0]          idx_m1;
  logic signed [V2W-1:0]  h_rd;
  logic signed [ACCW:0]   h_ext;
  logic signed [ACCW:0]   sum;
  logic signed [ACCW:0]   sum_adj;
  logic signed [ACCW-1:0] acc_abs;
  logic [DVW:0]           trial;
  logic [DVW:0]           dvs;
  logic [DVW:0]           trial_sub;
  logic signed [ACCW-1:0] q_ext;
  logic signed [ACCW-1:0] pred;
  logic signed [DW-1:0]   diff;
  logic signed [DW-1:0]   diff_adj;

  // history read, newest at entry zero
  assign idx_m1 = idx - 1'b1;
  assign h_rd   = hist[idx_m1[HAW-1:0]];

  // running sum step: halve 2*acc + h toward zero
  assign h_ext   = (ACCW+1)'(h_rd);
  assign sum     = $signed({acc, 1'b0}) + h_ext;
  assign sum_adj = sum + $signed({{ACCW{1'b0}}, sum[ACCW]});

  // divider operands
  assign acc_abs   = acc[ACCW-1] ? (-acc) : acc;
  assign trial     = {rem, quo[MAGW-1]};
  assign dvs       = {1'b0, used};
  assign trial_sub = trial - dvs;

  // signed prediction and halved residual
  assign q_ext    = $signed({1'b0, quo});
  assign pred     = neg ? (-q_ext) : q_ext;
  assign diff     = DW'(v2) - $signed({pred[ACCW-1], pred, 1'b0});
  assign diff_adj = diff + $signed({{(DW-1){1'b0}}, diff[DW-1]});
  assign residual = (used == '0) ? '0 : diff_adj[V2W:1];

  // value, sum and divider registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v2  <= v2_in;
      acc <= '0;
    end
    if (ctrl.walk) begin
      acc <= sum_adj[ACCW:1];
    end
    if (ctrl.div_load) begin
      neg <= acc[ACCW-1];
      rem <= '0;
      quo <= acc_abs[MAGW-1:0];
    end
    if (ctrl.div_step) begin
      if (trial >= dvs) begin
        rem <= trial_sub[DVW-1:0];
        quo <= {quo[MAGW-2:0], 1'b1};
      end else begin
        rem <= trial[DVW-1:0];
        quo <= {quo[MAGW-2:0], 1'b0};
      end
    end
  end

  // history shift on completion
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      hist[0] <= v2;
      for (int i = 1; i < HD; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

endmodule

// ----- hdl/mid_side_average_predict_residual.sv -----
// top level: config registers, window bookkeeping, sequencer, two lanes, output beat register
// Takes one left/right pair per input beat and returns one mid/side residual beat.
// Items are worked one at a time by a five-step microcode program. An item with an
// empty window (first sample after stream_start or reset) skips the walk and divide steps;
// otherwise the running-sum walk takes one step per history entry averaged (used, at
// most prediction_order-1, kept within 1..MAX_ORDER-1) and the serial divider takes
// one step per quotient bit, both lanes in parallel. A finished beat waits in the
// output register while the next input is taken; the next result step stalls only if
// that register is still full.
module mid_side_average_predict_residual import msap_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_ORDER   = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // apb config port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [2:0]                                   paddr,
  input  logic [31:0]                                  pwdata,
  output logic [31:0]                                  prdata,
  output logic                                         pready,
  // input beats
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,  // left_sample, right_sample
  input  logic                                         s_tuser,  // stream_start
  // result beats
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0]         m_tdata   // mid_residual, side_residual
);

  localparam int V2W  = SAMPLE_BITS + 1;
  localparam int IW   = $clog2(MAX_ORDER);
  localparam int ACCW = SAMPLE_BITS + IW + 1;
  localparam int MAGW = ACCW - 1;
  localparam int DCW  = $clog2(MAGW + 1);
  localparam int OUTW = ((2*SAMPLE_BITS+2+7)/8)*8;
  localparam logic [5:0] MAX_M1 = 6'(MAX_ORDER - 1);

  localparam logic       REG_STEREO_MODE      = 1'b0;
  localparam logic       REG_PREDICTION_ORDER = 1'b1;
  localparam logic [4:0] ORDER_RESET          = 5'd10;

  logic          stereo_mode;
  logic [4:0]    prediction_order;
  logic          stereo;
  logic [IW-1:0] fill;
  logic [IW-1:0] used;
  logic [IW-1:0] idx;
  logic [DCW-1:0] dcnt;

  logic                  cfg_wr;
  logic                  reg_sel;
  seq_status_t           status;
  seq_ctrl_t             sctrl;
  lane_ctrl_t            lctrl;
  logic                  out_free;

  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic signed [V2W-1:0]         mid_v2;
  logic signed [V2W-1:0]         side_v2;
  logic signed [V2W-1:0]         mid_residual;
  logic signed [V2W-1:0]         side_residual;

  logic [IW-1:0] fill_eff;
  logic [5:0]    ord_raw_m1;
  logic [5:0]    ord_m1;
  logic [5:0]    fill_ext;
  logic [IW-1:0] used_new;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_sel)
      REG_STEREO_MODE: prdata = {31'd0, stereo_mode};
      default:         prdata = {27'd0, prediction_order};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode      <= 1'b1;
      prediction_order <= ORDER_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_STEREO_MODE: stereo_mode      <= pwdata[0];
        default:         prediction_order <= pwdata[4:0];
      endcase
    end
  end

  // input fields and half-unit mid/side
  assign left_sample  = s_tdata[SAMPLE_BITS-1:0];
  assign right_sample = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign mid_v2  = stereo_mode ? (V2W'(left_sample) + V2W'(right_sample))
                               : $signed({left_sample, 1'b0});
  assign side_v2 = stereo_mode ? (V2W'(left_sample) - V2W'(right_sample)) : '0;

  // window size: clamped order minus one, limited by fill
  assign fill_eff   = s_tuser ? '0 : fill;
  assign ord_raw_m1 = {1'b0, prediction_order} - 6'd1;
  assign ord_m1     = (prediction_order < 5'd2) ? 6'd1 :
                      (ord_raw_m1 > MAX_M1) ? MAX_M1 : ord_raw_m1;
  assign fill_ext   = 6'(fill_eff);
  assign used_new   = (fill_ext < ord_m1) ? fill_eff : ord_m1[IW-1:0];

  // sequencer
  assign out_free = !m_tvalid || m_tready;
  assign status.in_valid  = s_tvalid;
  assign status.out_free  = out_free;
  assign status.idx_more  = (idx > IW'(1));
  assign status.used_zero = (used == '0);
  assign status.div_more  = (dcnt != DCW'(1));

  msap_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (sctrl)
  );

  // no beat is taken while reset is held
  assign s_tready = sctrl.in_ready & !rst;

  // lane strobes, walk skipped on an empty window
  assign lctrl.load     = (sctrl.op == OP_LOAD);
  assign lctrl.walk     = (sctrl.op == OP_WALK) && (idx != '0);
  assign lctrl.div_load = (sctrl.op == OP_DIV_LOAD);
  assign lctrl.div_step = (sctrl.op == OP_DIV_STEP);
  assign lctrl.finish   = (sctrl.op == OP_FINISH);

  // window, walk index and divider count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      used   <= '0;
      idx    <= '0;
      dcnt   <= '0;
      stereo <= 1'b0;
    end else begin
      if (lctrl.load) begin
        used   <= used_new;
        idx    <= used_new;
        stereo <= stereo_mode;
        fill   <= (fill_eff == IW'(MAX_ORDER - 1)) ? fill_eff : fill_eff + 1'b1;
      end
      if (lctrl.walk) begin
        idx <= idx - 1'b1;
      end
      if (lctrl.div_load) begin
        dcnt <= DCW'(MAGW);
      end
      if (lctrl.div_step) begin
        dcnt <= dcnt - 1'b1;
      end
    end
  end

  msap_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_ORDER   (MAX_ORDER)
  ) u_mid (
    .clk      (clk),
    .ctrl     (lctrl),
    .v2_in    (mid_v2),
    .idx      (idx),
    .used     (used),
    .residual (mid_residual)
  );

  msap_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_ORDER   (MAX_ORDER)
  ) u_side (
    .clk      (clk),
    .ctrl     (lctrl),
    .v2_in    (side_v2),
    .idx      (idx),
    .used     (used),
    .residual (side_residual)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (lctrl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lctrl.finish) begin
      m_tdata <= OUTW'({(stereo ? side_residual : {V2W{1'b0}}), mid_residual});
    end
  end

endmodule
